// ----- rtl/qvr_pkg.sv -----
// ----------------------------------------------------------------------------
// qvr_pkg: shared types and constants for the quaternion vector rotator
// Holds the fixed-point formats of the matrix elements, the vector lanes
// and the per-row partial sums.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int QUAT_W = 16;   // Q2.14 quaternion component
    localparam int VEC_W  = 32;   // Q16.16 vector component
    localparam int PROD_W = 32;   // product of two quaternion components
    localparam int ELEM_W = 35;   // matrix element, Q.28
    localparam int HI_W   = ELEM_W + 16;      // element times signed upper half
    localparam int LO_W   = ELEM_W + 17;      // element times unsigned lower half
    localparam int HSUM_W = HI_W + 2;
    localparam int LSUM_W = LO_W + 2;
    localparam int ACC_W  = LSUM_W;

    typedef logic signed [QUAT_W-1:0] t_quat;
    typedef logic signed [VEC_W-1:0]  t_vec;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ELEM_W-1:0] t_elem;

    localparam t_elem ONE_Q28 = t_elem'(64'sd268435456);
    localparam logic signed [LSUM_W-1:0] HALF_Q28 = LSUM_W'(64'sd134217728);

endpackage

// ----- rtl/qvr_row.sv -----
// ----------------------------------------------------------------------------
// qvr_row: one row of the rotation matrix times the input vector
// Three stages: split partial products, row sums, round and saturate to
// Q16.16.
// ----------------------------------------------------------------------------
module qvr_row
    import qvr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_elem i_m [3],
    input  t_vec  i_v [3],
    output logic  o_valid,
    output t_vec  o_res
);

    // stage 3: partial products, vector split into signed high and unsigned low halves
    logic                     r_v3;
    logic signed [HI_W-1:0]   r_hi [3];
    logic signed [LO_W-1:0]   r_lo [3];

    // stage 4: row sums
    logic                     r_v4;
    logic signed [HSUM_W-1:0] r_hsum;
    logic signed [LSUM_W-1:0] r_lsum;

    // stage 5: output
    logic                     r_v5;
    t_vec                     r_res;

    logic signed [15:0]       vh [3];
    logic signed [16:0]       vl [3];
    logic signed [HI_W-1:0]   n_hi [3];
    logic signed [LO_W-1:0]   n_lo [3];
    logic signed [HSUM_W-1:0] n_hsum;
    logic signed [LSUM_W-1:0] n_lsum;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_sh;
    logic                     ovf;
    t_vec                     n_res;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vh[i]   = i_v[i][31:16];
            vl[i]   = {1'b0, i_v[i][15:0]};
            n_hi[i] = HI_W'(i_m[i]) * HI_W'(vh[i]);
            n_lo[i] = LO_W'(i_m[i]) * LO_W'(vl[i]);
        end
    end

    always_comb begin
        n_hsum = HSUM_W'(r_hi[0]) + HSUM_W'(r_hi[1]) + HSUM_W'(r_hi[2]);
        n_lsum = LSUM_W'(r_lo[0]) + LSUM_W'(r_lo[1]) + LSUM_W'(r_lo[2]) + HALF_Q28;
    end

    // exact sum = hsum * 2^16 + lsum; round to Q16.16 by dropping 28 bits
    always_comb begin
        acc    = ACC_W'(r_hsum) + ACC_W'(r_lsum >>> 16);
        acc_sh = acc >>> 12;
        ovf    = (acc_sh[ACC_W-1:VEC_W-1] != {(ACC_W-VEC_W+1){acc_sh[ACC_W-1]}});
        if (ovf) begin
            n_res = acc_sh[ACC_W-1] ? {1'b1, {(VEC_W-1){1'b0}}} : {1'b0, {(VEC_W-1){1'b1}}};
        end else begin
            n_res = acc_sh[VEC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi   <= n_hi;
        r_lo   <= n_lo;
        r_hsum <= n_hsum;
        r_lsum <= n_lsum;
        r_res  <= n_res;
    end

    assign o_valid = r_v5;
    assign o_res   = r_res;

endmodule

// ----- rtl/quaternion_vector_rotate_top.sv -----
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top: rotate a Q16.16 vector by a Q2.14 quaternion
// Builds the rotation matrix from doubled quaternion products and returns
// the rounded, saturated matrix-vector product.
//
//   channel   signals                                  handshake
//   -------   --------------------------------------   ---------------------
//   in        i_quat_w/x/y/z, i_vec_x/y/z              start high, busy low
//   out       o_rot_x/y/z                              o_valid, one cycle
//
// Five register stages: quaternion products, matrix elements, split
// partial products, row sums, round/saturate. One item per cycle outside
// reset; the valid flag moves through r_v1 to r_v5 beside the data, and
// o_valid marks when the result is to be taken.
// Synchronous reset clears the valid chain; busy is high only in reset.
// The pipeline never stalls, so busy stays low outside reset.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_top
    import qvr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_quat i_quat_w,
    input  t_quat i_quat_x,
    input  t_quat i_quat_y,
    input  t_quat i_quat_z,
    input  t_vec  i_vec_x,
    input  t_vec  i_vec_y,
    input  t_vec  i_vec_z,
    output logic  o_valid,
    output t_vec  o_rot_x,
    output t_vec  o_rot_y,
    output t_vec  o_rot_z
);

    logic  accept;

    // stage 1: quaternion products
    logic  r_v1;
    t_prod r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_vec  r_vec1 [3];

    // stage 2: matrix elements
    logic  r_v2;
    t_elem r_m [3][3];
    t_vec  r_vec2 [3];

    t_elem d_xx, d_yy, d_zz, d_xy, d_xz, d_yz, d_wx, d_wy, d_wz;
    t_elem n_m [3][3];
    logic  row_valid [3];
    t_vec  row_res [3];

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xx      <= PROD_W'(i_quat_x) * PROD_W'(i_quat_x);
        r_yy      <= PROD_W'(i_quat_y) * PROD_W'(i_quat_y);
        r_zz      <= PROD_W'(i_quat_z) * PROD_W'(i_quat_z);
        r_xy      <= PROD_W'(i_quat_x) * PROD_W'(i_quat_y);
        r_xz      <= PROD_W'(i_quat_x) * PROD_W'(i_quat_z);
        r_yz      <= PROD_W'(i_quat_y) * PROD_W'(i_quat_z);
        r_wx      <= PROD_W'(i_quat_w) * PROD_W'(i_quat_x);
        r_wy      <= PROD_W'(i_quat_w) * PROD_W'(i_quat_y);
        r_wz      <= PROD_W'(i_quat_w) * PROD_W'(i_quat_z);
        r_vec1[0] <= i_vec_x;
        r_vec1[1] <= i_vec_y;
        r_vec1[2] <= i_vec_z;
    end

    // double each product by a left shift into the element width
    always_comb begin
        d_xx = ELEM_W'(r_xx) <<< 1;
        d_yy = ELEM_W'(r_yy) <<< 1;
        d_zz = ELEM_W'(r_zz) <<< 1;
        d_xy = ELEM_W'(r_xy) <<< 1;
        d_xz = ELEM_W'(r_xz) <<< 1;
        d_yz = ELEM_W'(r_yz) <<< 1;
        d_wx = ELEM_W'(r_wx) <<< 1;
        d_wy = ELEM_W'(r_wy) <<< 1;
        d_wz = ELEM_W'(r_wz) <<< 1;

        n_m[0][0] = ONE_Q28 - (d_yy + d_zz);
        n_m[0][1] = d_xy - d_wz;
        n_m[0][2] = d_xz + d_wy;
        n_m[1][0] = d_xy + d_wz;
        n_m[1][1] = ONE_Q28 - (d_xx + d_zz);
        n_m[1][2] = d_yz - d_wx;
        n_m[2][0] = d_xz - d_wy;
        n_m[2][1] = d_yz + d_wx;
        n_m[2][2] = ONE_Q28 - (d_xx + d_yy);
    end

    always_ff @(posedge i_clk) begin
        r_m    <= n_m;
        r_vec2 <= r_vec1;
    end

    for (genvar g = 0; g < 3; g++) begin : g_row
        qvr_row u_row (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_v2),
            .i_m     (r_m[g]),
            .i_v     (r_vec2),
            .o_valid (row_valid[g]),
            .o_res   (row_res[g])
        );
    end

    assign o_valid = row_valid[0];
    assign o_rot_x = row_res[0];
    assign o_rot_y = row_res[1];
    assign o_rot_z = row_res[2];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(accept, 5))
        else $error("result strobe does not follow accepted item by five cycles");

    a_rows_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (row_valid[0] == row_valid[1]) && (row_valid[1] == row_valid[2]))
        else $error("row pipelines out of step");

    a_no_busy: assert property (@(posedge i_clk)
        i_rst_n |-> !busy)
        else $error("busy raised outside reset");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v1 && !r_v2)
        else $error("valid chain not cleared by reset");

endmodule
